/* hw/rtl/rlts_pkg.sv */
// rlts_pkg: types, constants and state codes for the register list transfer sequencer
// no dependencies; imported by rlts_step_unit, the top level and the testbench
package rlts_pkg;

    localparam int ADDRESS_BITS = 24;
    localparam int REG_COUNT    = 16;
    localparam int CNT_W        = $clog2(REG_COUNT + 1);
    localparam int IDX_W        = $clog2(REG_COUNT);

    localparam logic [31:0] SPAN_MASK  = 32'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [31:0] STEP_WORD  = 32'd2;
    localparam logic [31:0] STEP_LONG  = 32'd4;
    localparam logic [7:0]  CYC_STORE  = 8'd8;
    localparam logic [7:0]  CYC_LOAD   = 8'd12;

    typedef struct packed {
        logic        to_memory;
        logic [15:0] reg_mask;
        logic        long_op;
        logic        addr_reg_mode;
        logic [31:0] start_address;
    } req_t;

    typedef struct packed {
        logic        transfer_valid;
        logic [3:0]  reg_index;
        logic [23:0] bus_address;
        logic        is_write;
        logic        is_long;
        logic        base_update;
        logic [31:0] final_address;
        logic [7:0]  cycle_count;
        logic        last;
    } rsp_t;

    // control into the shared step unit
    typedef struct packed {
        logic             down;
        logic             long_op;
        logic             to_memory;
        logic [CNT_W-1:0] count;
    } step_ctrl_t;

    typedef struct packed {
        logic [31:0] next_addr;
        logic [23:0] bus_addr;
        logic [7:0]  cycles;
    } step_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMPTY
    } state_t;

endpackage

/* hw/rtl/rlts_step_unit.sv */
// rlts_step_unit: shared address adder, bus address masking and cycle count
// depends on rlts_pkg
module rlts_step_unit (
    input  logic [31:0]         addr,
    input  rlts_pkg::step_ctrl_t ctrl,
    output rlts_pkg::step_res_t  res
);
    import rlts_pkg::*;

    logic [31:0] step;
    logic [31:0] delta;
    logic [31:0] sum;
    logic [31:0] bus_full;
    logic [7:0]  cyc_base;
    logic [7:0]  cyc_add;

    always_comb
    begin
        step  = ctrl.long_op ? STEP_LONG : STEP_WORD;
        delta = ctrl.down ? (~step + 32'd1) : step;
        sum   = addr + delta;
        // predecrement uses the lowered address, otherwise the current one
        bus_full = (ctrl.down ? sum : addr) & SPAN_MASK;
        cyc_base = ctrl.to_memory ? CYC_STORE : CYC_LOAD;
        cyc_add  = ctrl.long_op ? 8'({ctrl.count, 3'b000}) : 8'({ctrl.count, 2'b00});
        res.next_addr = sum;
        res.bus_addr  = bus_full[23:0];
        res.cycles    = cyc_base + cyc_add;
    end

endmodule

/* hw/rtl/register_list_transfer_sequencer_unit.sv */
// register_list_transfer_sequencer_unit: top level, scan sequencer and result register
// depends on rlts_pkg and rlts_step_unit
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | rlts_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | rlts_pkg::rsp_t
//
// a request scans its register list one bit per cycle through one shared adder,
// up to its last selected bit in scan order; the next request is taken once the
// sequencer is back in idle. req_stall is high until the last result is loaded
// into the result register. a stalled result holds the scan on its next selected
// register, so the scan only keeps its rate while the result register is free.
// reset clears state and the result valid flag only.
module register_list_transfer_sequencer_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rlts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rlts_pkg::rsp_t rsp
);
    import rlts_pkg::*;

    state_t            state_reg, state_next;
    logic [15:0]       mask_reg, mask_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       addr_reg, addr_next;
    logic              down_reg, down_next;
    logic              lng_reg, lng_next;
    logic              wr_reg, wr_next;
    logic              mode_reg, mode_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              req_take;
    logic              slot_free;
    logic              cur_bit;
    logic              rest_zero;
    logic              emit_scan;
    logic              emit_empty;
    logic              advance;
    logic              down_in;
    logic [15:0]       mask_rev;
    step_ctrl_t        step_ctrl;
    step_res_t         step_res;

    rlts_step_unit u_step (
        .addr (addr_reg),
        .ctrl (step_ctrl),
        .res  (step_res)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign cur_bit   = mask_reg[0];
    assign rest_zero = (mask_reg[15:1] == 15'd0);
    assign emit_scan  = (state_reg == ST_SCAN) && cur_bit && slot_free;
    assign emit_empty = (state_reg == ST_EMPTY) && slot_free;
    assign advance    = (state_reg == ST_SCAN) && (!cur_bit || slot_free);
    assign down_in    = req.to_memory && req.addr_reg_mode;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            mask_rev[i] = req.reg_mask[15-i];
        end
    end

    always_comb
    begin
        step_ctrl.down      = down_reg && (state_reg == ST_SCAN);
        step_ctrl.long_op   = lng_reg;
        step_ctrl.to_memory = wr_reg;
        step_ctrl.count     = (state_reg == ST_SCAN) ? count_reg + CNT_W'(1) : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (req.reg_mask == 16'd0) ? ST_EMPTY : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (emit_scan && rest_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (emit_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        down_next      = down_reg;
        lng_next       = lng_reg;
        wr_next        = wr_reg;
        mode_next      = mode_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        if (req_take)
        begin
            // predecrement lists are reversed so the scan always runs from bit 0
            mask_next  = down_in ? mask_rev : req.reg_mask;
            idx_next   = '0;
            count_next = '0;
            addr_next  = req.start_address;
            down_next  = down_in;
            lng_next   = req.long_op;
            wr_next    = req.to_memory;
            mode_next  = req.addr_reg_mode;
        end

        if (advance)
        begin
            mask_next = {1'b0, mask_reg[15:1]};
            idx_next  = idx_reg + IDX_W'(1);
            if (cur_bit)
            begin
                addr_next  = step_res.next_addr;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (emit_scan)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.transfer_valid = 1'b1;
            rsp_next.reg_index     = 4'(idx_reg);
            rsp_next.bus_address   = step_res.bus_addr;
            rsp_next.is_write      = wr_reg;
            rsp_next.is_long       = lng_reg;
            rsp_next.base_update   = rest_zero && mode_reg;
            rsp_next.final_address = rest_zero ? step_res.next_addr : 32'd0;
            rsp_next.cycle_count   = rest_zero ? step_res.cycles : 8'd0;
            rsp_next.last          = rest_zero;
        end
        else if (emit_empty)
        begin
            rsp_valid_next         = 1'b1;
            rsp_next.transfer_valid = 1'b0;
            rsp_next.reg_index     = 4'd0;
            rsp_next.bus_address   = 24'd0;
            rsp_next.is_write      = wr_reg;
            rsp_next.is_long       = lng_reg;
            rsp_next.base_update   = mode_reg;
            rsp_next.final_address = addr_reg;
            rsp_next.cycle_count   = step_res.cycles;
            rsp_next.last          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        idx_reg   <= idx_next;
        count_reg <= count_next;
        addr_reg  <= addr_next;
        down_reg  <= down_next;
        lng_reg   <= lng_next;
        wr_reg    <= wr_next;
        mode_reg  <= mode_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a scan never runs with an exhausted list
    a_scan_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (mask_reg != 16'd0))
        else $error("scan with empty remaining mask");

    // only the last transfer carries the summary fields
    a_not_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.last) |->
            (rsp.cycle_count == 8'd0 && rsp.final_address == 32'd0 && !rsp.base_update))
        else $error("summary fields on a non-last transfer");

    // an empty-list result is always the last one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.transfer_valid) |-> rsp.last)
        else $error("empty-list result without last");

    // a taken request moves the sequencer out of idle, so no new request is taken until it has finished
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("request taken but sequencer stayed idle");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking testbench for register_list_transfer_sequencer_unit
// depends on rlts_pkg and the rtl of the sequencer; the expected transfers come
// from an in-line predictor held by a small scoreboard class
module tb;

    import rlts_pkg::*;

    class transfer_scoreboard;
        rsp_t expected_transfers[$];
        int   failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return expected_transfers.size();
        endfunction

        // expand one request into its bus transfers, in bus order
        function void note_request(req_t r);
            rsp_t        batch[$];
            rsp_t        t;
            logic [31:0] addr;
            logic [31:0] step;
            logic [31:0] masked;
            logic [7:0]  cycles;
            bit          down;
            int          count;
            int          bitpos;
            addr   = r.start_address;
            step   = r.long_op ? STEP_LONG : STEP_WORD;
            down   = r.to_memory && r.addr_reg_mode;
            count  = 0;
            for (int k = 0; k < REG_COUNT; k++)
            begin
                bitpos = down ? (15 - k) : k;
                if (r.reg_mask[bitpos])
                begin
                    t = '0;
                    if (down)
                    begin
                        addr   = addr - step;
                        masked = addr & SPAN_MASK;
                        t.reg_index = 4'(15 - bitpos);
                    end
                    else
                    begin
                        masked = addr & SPAN_MASK;
                        addr   = addr + step;
                        t.reg_index = 4'(bitpos);
                    end
                    t.transfer_valid = 1'b1;
                    t.bus_address    = masked[23:0];
                    t.is_write       = r.to_memory;
                    t.is_long        = r.long_op;
                    batch.push_back(t);
                    count++;
                end
            end
            cycles = (r.to_memory ? CYC_STORE : CYC_LOAD)
                     + 8'(count * (r.long_op ? 8 : 4));
            // empty list still yields one closing transfer
            if (count == 0)
            begin
                t = '0;
                t.is_write = r.to_memory;
                t.is_long  = r.long_op;
                batch.push_back(t);
            end
            t = batch.pop_back();
            t.base_update   = r.addr_reg_mode;
            t.final_address = addr;
            t.cycle_count   = cycles;
            t.last          = 1'b1;
            batch.push_back(t);
            foreach (batch[i])
                expected_transfers.push_back(batch[i]);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            bit   bad;
            if (expected_transfers.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t unexpected transfer reg=%0d bus=%h last=%0d",
                             $realtime, got.reg_index, got.bus_address, got.last);
                return;
            end
            exp = expected_transfers.pop_front();
            bad = (got.transfer_valid !== exp.transfer_valid)
                  || (got.reg_index !== exp.reg_index)
                  || (got.bus_address !== exp.bus_address)
                  || (got.is_write !== exp.is_write)
                  || (got.is_long !== exp.is_long)
                  || (got.base_update !== exp.base_update)
                  || (got.final_address !== exp.final_address)
                  || (got.cycle_count !== exp.cycle_count)
                  || (got.last !== exp.last);
            if (bad)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("%0t mismatch exp tv=%0d reg=%0d bus=%h wr=%0d lg=%0d",
                             $realtime, exp.transfer_valid, exp.reg_index,
                             exp.bus_address, exp.is_write, exp.is_long);
                    $display("    exp bu=%0d fin=%h cyc=%0d last=%0d",
                             exp.base_update, exp.final_address,
                             exp.cycle_count, exp.last);
                    $display("    got tv=%0d reg=%0d bus=%h wr=%0d lg=%0d",
                             got.transfer_valid, got.reg_index,
                             got.bus_address, got.is_write, got.is_long);
                    $display("    got bu=%0d fin=%h cyc=%0d last=%0d",
                             got.base_update, got.final_address,
                             got.cycle_count, got.last);
                end
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    transfer_scoreboard sb = new();
    bit no_idle   = 1'b0;
    int stall_left = 0;

    register_list_transfer_sequencer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short idle runs, now and then a long one
    function int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function int request_gap();
        if (no_idle || $urandom_range(0, 9) < 4)
            return 0;
        return idle_length();
    endfunction

    function req_t make_request(bit wr, logic [15:0] mask, bit lng, bit mode,
                                logic [31:0] addr);
        req_t r;
        r.to_memory     = wr;
        r.reg_mask      = mask;
        r.long_op       = lng;
        r.addr_reg_mode = mode;
        r.start_address = addr;
        return r;
    endfunction

    function req_t random_request();
        req_t r;
        int   sel;
        r.to_memory     = 1'($urandom_range(0, 1));
        r.long_op       = 1'($urandom_range(0, 1));
        r.addr_reg_mode = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        if (sel == 0)
            r.reg_mask = 16'h0000;
        else if (sel == 1)
            r.reg_mask = 16'hFFFF;
        else if (sel == 2)
            r.reg_mask = 16'h0001 << $urandom_range(0, 15);
        else
            r.reg_mask = 16'($urandom_range(0, 65535));
        sel = $urandom_range(0, 7);
        // addresses near the wrap points of the 32-bit and 24-bit ranges
        if (sel == 0)
            r.start_address = 32'($urandom_range(0, 63));
        else if (sel == 1)
            r.start_address = 32'hFFFF_FFC0 + 32'($urandom_range(0, 63));
        else if (sel == 2)
            r.start_address = {8'($urandom_range(0, 255)), 24'hFFFFE0}
                              + 32'($urandom_range(0, 63));
        else
            r.start_address = $urandom();
        return r;
    endfunction

    task send_request(input req_t r);
        int gap;
        gap = request_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lists in every direction and mode
        send_request(make_request(1'b1, 16'h0000, 1'b0, 1'b0, 32'h0000_0000));
        send_request(make_request(1'b0, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(1'b1, 16'h0000, 1'b1, 1'b1, 32'h0000_1234));
        send_request(make_request(1'b0, 16'h0000, 1'b0, 1'b0, 32'h8000_0000));
        // full lists, with wrap through zero
        send_request(make_request(1'b1, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0000));
        send_request(make_request(1'b0, 16'hFFFF, 1'b0, 1'b1, 32'hFFFF_FFFE));
        send_request(make_request(1'b1, 16'hFFFF, 1'b1, 1'b0, 32'h00FF_FFF0));
        send_request(make_request(1'b0, 16'hFFFF, 1'b1, 1'b0, 32'h7FFF_FFFC));
        // single registers at both ends of the list
        send_request(make_request(1'b1, 16'h0001, 1'b0, 1'b1, 32'h0000_0100));
        send_request(make_request(1'b1, 16'h8000, 1'b0, 1'b1, 32'h0000_0100));
        send_request(make_request(1'b0, 16'h0001, 1'b1, 1'b1, 32'h0000_0100));
        send_request(make_request(1'b0, 16'h8000, 1'b1, 1'b1, 32'h0000_0100));
        // bus address above 24 bits is cut back
        send_request(make_request(1'b1, 16'h0040, 1'b1, 1'b1, 32'h0100_0004));
        send_request(make_request(1'b0, 16'h0040, 1'b0, 1'b0, 32'hABFF_FFFE));
        send_request(make_request(1'b1, 16'h8001, 1'b0, 1'b1, 32'hFFFF_FFFF));
        send_request(make_request(1'b1, 16'hAAAA, 1'b0, 1'b0, 32'h00FF_FFFE));
        send_request(make_request(1'b0, 16'h5555, 1'b1, 1'b1, 32'h12FF_FFFC));
        send_request(make_request(1'b0, 16'hFF00, 1'b1, 1'b1, 32'h8000_0000));
        send_request(make_request(1'b1, 16'h00FF, 1'b0, 1'b1, 32'h0000_0002));

        for (int i = 0; i < 410; i++)
        begin
            no_idle = (i >= 150 && i < 200) || (i >= 340 && i < 370);
            send_request(random_request());
        end
        req_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);

        if (sb.failures == 0)
            $display("[register_list_transfer_sequencer_unit] OK");
        else
            $display("[register_list_transfer_sequencer_unit] ERROR");
        $finish;
    end

    initial
    begin
        #10_400_000;
        $display("[register_list_transfer_sequencer_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rlts_pkg.sv
hw/rtl/rlts_step_unit.sv
hw/rtl/register_list_transfer_sequencer_unit.sv
tb/tb.sv
